[rtl/sorted_first_last_occurrence_core_macros.svh]
// ----------------------------------------------------------------------------
// sorted first/last occurrence core assertion macros
// shared property shorthands for the checker, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef SORTED_FIRST_LAST_OCCURRENCE_CORE_MACROS_SVH
`define SORTED_FIRST_LAST_OCCURRENCE_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SFLO_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFLO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sflo_pkg.sv]
// ----------------------------------------------------------------------------
// sflo_pkg
// shared types and constants of the sorted first/last occurrence core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sflo_pkg;

	// default number of stored elements
	localparam int unsigned DEPTH_DEF = 1024;

	// item field widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 10;

	// item commands
	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_FIRST  = 2'd1,
		CMD_LAST   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

endpackage

`default_nettype wire

[rtl/sflo_if.sv]
// ----------------------------------------------------------------------------
// sflo_if
// valid/ready channels for command items and search result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// command item channel
interface sflo_in_if;
	logic                                  valid;
	logic                                  ready;
	sflo_pkg::cmd_t                        command;
	logic signed [sflo_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

// result item channel
interface sflo_out_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [sflo_pkg::POS_W-1:0]    position;

	modport source (output valid, output found, output position, input ready);
	modport sink (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

[rtl/sflo_ram.sv]
// ----------------------------------------------------------------------------
// sflo_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sflo_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/sorted_first_last_occurrence_core.sv]
// ----------------------------------------------------------------------------
// sorted_first_last_occurrence_core
// sorted word store with binary search for the first or last index of a key
// ----------------------------------------------------------------------------
// Append items write one element per cycle, while no find runs, into a block
// ram at the current fill count (appends into a full store are dropped);
// clear resets the count. A find item runs a binary search over the stored
// elements: each probe puts the address out in the search state, then
// compares on the registered ram data in the probe state. The ram read
// latency in that probe loop sets the find rate. One item is worked on at a
// time; a finished result sits in an output register, so the next item is
// taken while it waits. The store is not cleared at reset, only the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_first_last_occurrence_core #(
	parameter int unsigned DEPTH = sflo_pkg::DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sflo_in_if.sink    in_item,
	sflo_out_if.source out_item
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_PROBE  = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	state_t                                state_q;
	logic [CW-1:0]                         count_q;
	logic [CW-1:0]                         lo_q;
	logic [CW-1:0]                         hi1_q;
	logic [IW-1:0]                         mid_q;
	logic signed [sflo_pkg::VALUE_W-1:0]   key_q;
	logic                                  last_q;
	logic                                  hit_q;
	logic [IW-1:0]                         hit_idx_q;
	logic                                  out_valid_q;
	logic                                  found_q;
	logic [sflo_pkg::POS_W-1:0]            pos_q;

	logic                                  in_acc;
	logic                                  out_free;
	logic                                  not_full;
	logic                                  ram_we;
	logic [CW:0]                           mid_sum;
	logic [IW-1:0]                         mid_c;
	logic [sflo_pkg::VALUE_W-1:0]          rdata;
	logic signed [sflo_pkg::VALUE_W-1:0]   probe;
	logic                                  key_eq;
	logic                                  key_gt;
	logic [CW-1:0]                         mid_up;

	// handshakes
	assign in_item.ready  = (state_q == ST_IDLE);
	assign in_acc         = in_item.valid && in_item.ready;
	assign out_free       = !out_valid_q || out_item.ready;
	assign out_item.valid = out_valid_q;
	assign out_item.found = found_q;
	assign out_item.position = pos_q;

	// append path
	assign not_full = (count_q < CW'(DEPTH));
	assign ram_we   = in_acc && (in_item.command == sflo_pkg::CMD_APPEND) && not_full;

	// midpoint of the live window [lo, hi1), valid while lo < hi1
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi1_q} - (CW + 1)'(1);
	assign mid_c   = mid_sum[IW:1];
	assign mid_up  = CW'(mid_q) + CW'(1);

	// compare key with the probed element
	assign probe  = signed'(rdata);
	assign key_eq = (key_q == probe);
	assign key_gt = (key_q > probe);

	sflo_ram #(
		.WIDTH (sflo_pkg::VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (in_item.value),
		.raddr (mid_c),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_item.command)
							sflo_pkg::CMD_APPEND: begin
								if (not_full) begin
									count_q <= count_q + CW'(1);
								end
							end
							sflo_pkg::CMD_CLEAR: begin
								count_q <= '0;
							end
							sflo_pkg::CMD_FIRST, sflo_pkg::CMD_LAST: begin
								hit_q   <= 1'b0;
								state_q <= ST_SEARCH;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SEARCH: begin
					state_q <= (lo_q < hi1_q) ? ST_PROBE : ST_RESP;
				end
				ST_PROBE: begin
					if (key_eq) begin
						hit_q <= 1'b1;
					end
					state_q <= ST_SEARCH;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// output register valid
			priority if ((state_q == ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_item.ready) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

	// search window and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lo_q   <= '0;
			hi1_q  <= count_q;
			key_q  <= in_item.value;
			last_q <= (in_item.command == sflo_pkg::CMD_LAST);
		end
		if (state_q == ST_SEARCH) begin
			mid_q <= mid_c;
		end
		if (state_q == ST_PROBE) begin
			// on a match keep narrowing toward the wanted boundary
			priority if (key_eq) begin
				hit_idx_q <= mid_q;
				if (last_q) begin
					lo_q <= mid_up;
				end else begin
					hi1_q <= CW'(mid_q);
				end
			end else if (key_gt) begin
				lo_q <= mid_up;
			end else begin
				hi1_q <= CW'(mid_q);
			end
		end
		if ((state_q == ST_RESP) && out_free) begin
			found_q <= hit_q;
			pos_q   <= hit_q ? sflo_pkg::POS_W'(hit_idx_q) : '0;
		end
	end

endmodule

`default_nettype wire

[rtl/sflo_checker.sv]
// ----------------------------------------------------------------------------
// sflo_checker
// port level checks of the sorted first/last occurrence core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_first_last_occurrence_core_macros.svh"

module sflo_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic [sflo_pkg::CMD_W-1:0]    in_command,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          out_found,
	input wire logic [sflo_pkg::POS_W-1:0]    out_position
);

	logic in_find;
	logic in_other;

	assign in_find = in_valid && in_ready &&
		((in_command == sflo_pkg::CMD_FIRST) || (in_command == sflo_pkg::CMD_LAST));
	assign in_other = in_valid && in_ready &&
		((in_command == sflo_pkg::CMD_APPEND) || (in_command == sflo_pkg::CMD_CLEAR));

	// a waiting result item holds until taken
	`SFLO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_position), "result item changed while stalled")

	// a miss reports position zero
	`SFLO_ASSERT_SAME(a_miss_pos, out_valid && !out_found, out_position == '0, "miss with nonzero position")

	// a find keeps the input closed while it searches and cannot answer at once
	`SFLO_ASSERT_NEXT(a_find_busy, in_find, !in_ready && !$rose(out_valid), "find item not handled as a search")

	// append and clear leave the input ready in the cycle after they are taken
	`SFLO_ASSERT_NEXT(a_quick_cmd, in_other, in_ready, "append or clear blocked the input")

endmodule

bind sorted_first_last_occurrence_core sflo_checker u_sflo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_item.valid),
	.in_ready     (in_item.ready),
	.in_command   (in_item.command),
	.out_valid    (out_item.valid),
	.out_ready    (out_item.ready),
	.out_found    (out_item.found),
	.out_position (out_item.position)
);

`default_nettype wire
